[rtl/dtq_pkg.sv]
// ----------------------------------------------------------------------------
// Deadline timer queue package
// Operation and result codes, state encoding and the decoded request type.
// ----------------------------------------------------------------------------
`default_nettype none
package dtq_pkg;

   localparam int TimeWidth = 63;

   typedef enum logic [2:0] {
      OP_ALLOC   = 3'd0,
      OP_RELEASE = 3'd1,
      OP_ARM     = 3'd2,
      OP_DISARM  = 3'd3,
      OP_TICK    = 3'd4,
      OP_QUERY   = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      KIND_OK    = 3'd0,
      KIND_ERROR = 3'd1,
      KIND_FIRED = 3'd2,
      KIND_DELAY = 3'd3,
      KIND_NONE  = 3'd4,
      KIND_QUERY = 3'd5
   } kind_type;

   typedef enum logic [2:0] {
      CLS_ALLOC,
      CLS_RELEASE,
      CLS_ARM,
      CLS_DISARM,
      CLS_TICK,
      CLS_QUERY,
      CLS_BAD
   } cls_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_READ,
      S_OP,
      S_ALLOC,
      S_TRD,
      S_TEVAL,
      S_TUPD,
      S_TDIFF,
      S_TCLAMP
   } state_type;

   localparam logic CSR_MIN_DELAY = 1'b0;
   localparam logic CSR_MAX_DELAY = 1'b1;

   typedef logic [TimeWidth-1:0] time_type;

   typedef struct packed {
      cls_type    cls;
      logic       range_ok;
      logic [3:0] slot;
      time_type   time_value;
      time_type   reload;
      logic       absolute;
      time_type   now;
   } cmd_type;

   // Saturating 63-bit add
   function automatic time_type sat_add(input time_type a, input time_type b);
      logic [TimeWidth:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TimeWidth] ? {TimeWidth{1'b1}} : s[TimeWidth-1:0];
   endfunction

   // a - b, floored at zero
   function automatic time_type sat_sub(input time_type a, input time_type b);
      logic [TimeWidth:0] d;
      d = {1'b0, a} - {1'b0, b};
      return d[TimeWidth] ? '0 : d[TimeWidth-1:0];
   endfunction

endpackage
`default_nettype wire

[rtl/dtq_if.sv]
// ----------------------------------------------------------------------------
// Deadline timer queue channels
// Request and response channel interfaces with valid/ready handshake.
// ----------------------------------------------------------------------------
`default_nettype none
interface dtq_req_if;
   logic        valid;
   logic        ready;
   logic [2:0]  operation;
   logic [3:0]  slot;
   logic [62:0] time_value;
   logic [62:0] reload;
   logic        absolute;
   logic [62:0] now;
   modport source (output valid, operation, slot, time_value, reload, absolute, now,
                   input ready);
   modport sink   (input valid, operation, slot, time_value, reload, absolute, now,
                   output ready);
endinterface

interface dtq_rsp_if;
   logic        valid;
   logic        ready;
   logic [2:0]  kind;
   logic [3:0]  result_slot;
   logic [62:0] amount;
   logic [62:0] period;
   logic        last;
   modport source (output valid, kind, result_slot, amount, period, last, input ready);
   modport sink   (input valid, kind, result_slot, amount, period, last, output ready);
endinterface
`default_nettype wire

[rtl/deadline_timer_queue_top.sv]
// ----------------------------------------------------------------------------
// Deadline timer queue
// Software timer table with allocate, release, arm, disarm, query and tick.
// ----------------------------------------------------------------------------
// Usage:
//   req_bus carries one request (operation, slot, times); rsp_bus returns one
//   response per request, or for a tick one fired response per expired slot
//   followed by a next-delay or nothing-pending response; last marks the end.
//   csr_* writes min_delay (index 0) and max_delay (index 1); write only idle.
// Sequencing:
//   A two-entry request queue decouples req_bus from the sequencer.
//   Release, arm, disarm, query and bad requests pass through queue pop,
//   table read and execute. Allocate scans one slot a cycle.
//   Tick visits each slot in turn (read, compare, update), then computes the
//   next delay and clamps it; the clamp step is skipped when nothing is pending.
//   The slot table has one read port and one write port.
// Reset:
//   Synchronous; all slots become free and unarmed, the queue empties and the
//   delay limits return to 1000 and 2^32-1. The expiry and interval table is
//   not cleared; it is only read for armed slots.
// Backpressure:
//   The response register holds while rsp_bus.ready is low; the sequencer
//   stalls, and requests keep filling the queue until it is full.
// ----------------------------------------------------------------------------
`default_nettype none
module deadline_timer_queue_top #(
   parameter int NUM_SLOTS = 16
) (
   input  wire        clock,
   input  wire        reset,
   dtq_req_if.sink    req_bus,
   dtq_rsp_if.source  rsp_bus,
   input  wire        csr_write_enable,
   input  wire        csr_index,
   input  wire [31:0] csr_write_data
);
   import dtq_pkg::*;

   logic    q_valid;
   logic    q_pop;
   cmd_type q_head;
   logic [31:0] min_delay_ff, max_delay_ff;

   // hold the delay limits
   always_ff @(posedge clock) begin
      if (reset) begin
         min_delay_ff <= 32'd1000;
         max_delay_ff <= 32'hFFFF_FFFF;
      end else if (csr_write_enable) begin
         if (csr_index == CSR_MIN_DELAY) min_delay_ff <= csr_write_data;
         if (csr_index == CSR_MAX_DELAY) max_delay_ff <= csr_write_data;
      end
   end

   // decode and queue requests
   dtq_front #(.NUM_SLOTS(NUM_SLOTS)) u_front (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .q_valid (q_valid),
      .q_pop   (q_pop),
      .q_head  (q_head)
   );

   // execute requests against the slot table
   dtq_back #(.NUM_SLOTS(NUM_SLOTS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .q_valid   (q_valid),
      .q_pop     (q_pop),
      .q_head    (q_head),
      .min_delay (min_delay_ff),
      .max_delay (max_delay_ff),
      .rsp_bus   (rsp_bus)
   );

endmodule
`default_nettype wire

[rtl/dtq_front.sv]
// ----------------------------------------------------------------------------
// Deadline timer queue front end
// Decode requests and hold them in a two-entry queue for the back end.
// ----------------------------------------------------------------------------
`default_nettype none
module dtq_front #(
   parameter int NUM_SLOTS = 16
) (
   input  wire              clock,
   input  wire              reset,
   dtq_req_if.sink          req_bus,
   output logic             q_valid,
   input  wire              q_pop,
   output dtq_pkg::cmd_type q_head
);
   import dtq_pkg::*;

   cmd_type    ent_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   cmd_type    dec;
   logic       push;

   assign req_bus.ready = (count_ff != 2'd2);
   assign push    = req_bus.valid && req_bus.ready;
   assign q_valid = (count_ff != 2'd0);
   assign q_head  = ent_ff[rd_ptr_ff];

   always_comb begin
      dec.slot       = req_bus.slot;
      dec.range_ok   = ({28'd0, req_bus.slot} < 32'(NUM_SLOTS));
      dec.time_value = req_bus.time_value;
      dec.reload     = req_bus.reload;
      dec.absolute   = req_bus.absolute;
      dec.now        = req_bus.now;
      case (req_bus.operation)
         OP_ALLOC:   dec.cls = CLS_ALLOC;
         OP_RELEASE: dec.cls = CLS_RELEASE;
         OP_ARM:     dec.cls = CLS_ARM;
         OP_DISARM:  dec.cls = CLS_DISARM;
         OP_TICK:    dec.cls = CLS_TICK;
         OP_QUERY:   dec.cls = CLS_QUERY;
         default:    dec.cls = CLS_BAD;
      endcase
   end

   always_comb begin
      wr_ptr_in = wr_ptr_ff ^ push;
      rd_ptr_in = rd_ptr_ff ^ (q_pop && q_valid);
      count_in  = count_ff + {1'b0, push} - {1'b0, q_pop && q_valid};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         ent_ff[wr_ptr_ff] <= dec;
      end
   end

endmodule
`default_nettype wire

[rtl/dtq_back.sv]
// ----------------------------------------------------------------------------
// Deadline timer queue back end
// Sequence each request over the slot table and drive the response register.
// ----------------------------------------------------------------------------
`default_nettype none
module dtq_back #(
   parameter int NUM_SLOTS = 16
) (
   input  wire              clock,
   input  wire              reset,
   input  wire              q_valid,
   output logic             q_pop,
   input  dtq_pkg::cmd_type q_head,
   input  wire [31:0]       min_delay,
   input  wire [31:0]       max_delay,
   dtq_rsp_if.source        rsp_bus
);
   import dtq_pkg::*;

   localparam int SW = (NUM_SLOTS > 2) ? $clog2(NUM_SLOTS) : 1;
   localparam int XW = (SW > 4) ? SW : 4;

   state_type state_ff, state_in;
   cmd_type   cmd_ff, cmd_in;
   logic [SW-1:0] idx_ff, idx_in;
   logic [NUM_SLOTS-1:0] inuse_ff, inuse_in, armed_ff, armed_in;
   time_type  best_ff, best_in, nexp_ff, nexp_in, d_ff, d_in;
   logic      any_ff, any_in, fire_ff, fire_in, per_ff, per_in;

   time_type  exp_mem [NUM_SLOTS];
   time_type  int_mem [NUM_SLOTS];
   time_type  rexp_ff, rint_ff;
   logic [SW-1:0] raddr, waddr;
   logic      we;
   time_type  wexp, wint;

   logic      rv_ff, rv_in, rlast_ff, rlast_in;
   kind_type  rkind_ff, rkind_in;
   logic [3:0] rslot_ff, rslot_in;
   time_type  ramt_ff, ramt_in, rper_ff, rper_in;

   logic [XW-1:0] cs_ext, ci_ext;
   logic [SW-1:0] sidx;
   logic      out_free, ok_slot, last_idx, emit, cand_ok;
   time_type  cand;

   assign cs_ext   = XW'(cmd_ff.slot);
   assign sidx     = cs_ext[SW-1:0];
   assign ci_ext   = XW'(idx_ff);
   assign ok_slot  = cmd_ff.range_ok && inuse_ff[sidx];
   assign out_free = !rv_ff || rsp_bus.ready;
   assign last_idx = (idx_ff == SW'(NUM_SLOTS - 1));

   assign rsp_bus.valid       = rv_ff;
   assign rsp_bus.kind        = rkind_ff;
   assign rsp_bus.result_slot = rslot_ff;
   assign rsp_bus.amount      = ramt_ff;
   assign rsp_bus.period      = rper_ff;
   assign rsp_bus.last        = rlast_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               case (q_head.cls)
                  CLS_ALLOC: state_in = S_ALLOC;
                  CLS_TICK:  state_in = S_TRD;
                  default:   state_in = S_READ;
               endcase
            end
         end
         S_READ:  state_in = S_OP;
         S_OP:    if (out_free) state_in = S_IDLE;
         S_ALLOC: begin
            if (!inuse_ff[idx_ff] || last_idx) begin
               if (out_free) state_in = S_IDLE;
            end
         end
         S_TRD:   state_in = S_TEVAL;
         S_TEVAL: state_in = S_TUPD;
         S_TUPD: begin
            if (!fire_ff || out_free) state_in = last_idx ? S_TDIFF : S_TRD;
         end
         S_TDIFF: begin
            if (any_ff) state_in = S_TCLAMP;
            else if (out_free) state_in = S_IDLE;
         end
         S_TCLAMP: if (out_free) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   // datapath and outputs
   always_comb begin
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      inuse_in = inuse_ff;
      armed_in = armed_ff;
      best_in  = best_ff;
      any_in   = any_ff;
      nexp_in  = nexp_ff;
      fire_in  = fire_ff;
      per_in   = per_ff;
      d_in     = d_ff;
      q_pop    = 1'b0;
      // keep the addressed slot on the read port while execute waits
      raddr    = (state_ff == S_READ || state_ff == S_OP) ? sidx : idx_ff;
      we       = 1'b0;
      waddr    = idx_ff;
      wexp     = nexp_ff;
      wint     = rint_ff;
      emit     = 1'b0;
      rkind_in = KIND_OK;
      rslot_in = 4'd0;
      ramt_in  = '0;
      rper_in  = '0;
      rlast_in = 1'b1;
      cand     = rexp_ff;
      cand_ok  = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (q_valid) begin
               q_pop  = 1'b1;
               cmd_in = q_head;
               idx_in = '0;
               any_in = 1'b0;
            end
         end
         S_OP: begin
            if (out_free) begin
               emit     = 1'b1;
               rslot_in = cmd_ff.slot;
               if (cmd_ff.cls == CLS_BAD || !ok_slot) begin
                  rkind_in = KIND_ERROR;
                  rslot_in = 4'd0;
               end else begin
                  case (cmd_ff.cls)
                     CLS_RELEASE: begin
                        inuse_in[sidx] = 1'b0;
                        armed_in[sidx] = 1'b0;
                     end
                     CLS_DISARM: armed_in[sidx] = 1'b0;
                     CLS_QUERY: begin
                        rkind_in = KIND_QUERY;
                        if (armed_ff[sidx]) begin
                           ramt_in = sat_sub(rexp_ff, cmd_ff.now);
                           rper_in = rint_ff;
                        end
                     end
                     CLS_ARM: begin
                        if (armed_ff[sidx]) begin
                           ramt_in = sat_sub(rexp_ff, cmd_ff.now);
                           rper_in = rint_ff;
                        end
                        armed_in[sidx] = (cmd_ff.time_value != '0);
                        we    = (cmd_ff.time_value != '0);
                        waddr = sidx;
                        wexp  = cmd_ff.absolute ? cmd_ff.time_value
                                                : sat_add(cmd_ff.time_value, cmd_ff.now);
                        wint  = cmd_ff.reload;
                     end
                     default: rkind_in = KIND_ERROR;
                  endcase
               end
            end
         end
         S_ALLOC: begin
            if (!inuse_ff[idx_ff]) begin
               if (out_free) begin
                  emit             = 1'b1;
                  rslot_in         = ci_ext[3:0];
                  inuse_in[idx_ff] = 1'b1;
                  armed_in[idx_ff] = 1'b0;
               end
            end else if (last_idx) begin
               if (out_free) begin
                  emit     = 1'b1;
                  rkind_in = KIND_ERROR;
               end
            end else begin
               idx_in = idx_ff + 1'b1;
            end
         end
         S_TEVAL: begin
            fire_in = armed_ff[idx_ff] && (rexp_ff <= cmd_ff.now);
            nexp_in = sat_add(cmd_ff.now, rint_ff);
            per_in  = (rint_ff != '0);
         end
         S_TUPD: begin
            if (!fire_ff || out_free) begin
               if (fire_ff) begin
                  emit     = 1'b1;
                  rkind_in = KIND_FIRED;
                  rslot_in = ci_ext[3:0];
                  rlast_in = 1'b0;
                  if (per_ff) begin
                     we      = 1'b1;
                     cand    = nexp_ff;
                     cand_ok = 1'b1;
                  end else begin
                     armed_in[idx_ff] = 1'b0;
                  end
               end else begin
                  cand_ok = armed_ff[idx_ff];
               end
               if (cand_ok && (!any_ff || cand < best_ff)) begin
                  best_in = cand;
                  any_in  = 1'b1;
               end
               if (!last_idx) idx_in = idx_ff + 1'b1;
            end
         end
         S_TDIFF: begin
            d_in = sat_sub(best_ff, cmd_ff.now);
            if (!any_ff && out_free) begin
               emit     = 1'b1;
               rkind_in = KIND_NONE;
            end
         end
         S_TCLAMP: begin
            if (out_free) begin
               emit     = 1'b1;
               rkind_in = KIND_DELAY;
               if (d_ff < {31'd0, min_delay}) ramt_in = {31'd0, min_delay};
               else if (d_ff > {31'd0, max_delay}) ramt_in = {31'd0, max_delay};
               else ramt_in = d_ff;
            end
         end
         default: ;
      endcase
      rv_in = emit || (rv_ff && !rsp_bus.ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         inuse_ff <= '0;
         armed_ff <= '0;
         rv_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         inuse_ff <= inuse_in;
         armed_ff <= armed_in;
         rv_ff    <= rv_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff  <= cmd_in;
      idx_ff  <= idx_in;
      best_ff <= best_in;
      any_ff  <= any_in;
      nexp_ff <= nexp_in;
      fire_ff <= fire_in;
      per_ff  <= per_in;
      d_ff    <= d_in;
      if (emit) begin
         rkind_ff <= rkind_in;
         rslot_ff <= rslot_in;
         ramt_ff  <= ramt_in;
         rper_ff  <= rper_in;
         rlast_ff <= rlast_in;
      end
   end

   // slot table memory
   always_ff @(posedge clock) begin
      if (we) begin
         exp_mem[waddr] <= wexp;
         int_mem[waddr] <= wint;
      end
      rexp_ff <= exp_mem[raddr];
      rint_ff <= int_mem[raddr];
   end

endmodule
`default_nettype wire

[rtl/dtq_checker.sv]
// ----------------------------------------------------------------------------
// Deadline timer queue checker
// Port-level assertions on the response channel.
// ----------------------------------------------------------------------------
`default_nettype none
module dtq_checker (
   input wire        clock,
   input wire        reset,
   input wire        rsp_valid,
   input wire        rsp_ready,
   input wire [2:0]  rsp_kind,
   input wire [3:0]  rsp_result_slot,
   input wire [62:0] rsp_amount,
   input wire [62:0] rsp_period,
   input wire        rsp_last
);
   import dtq_pkg::*;

   a_reset_clear: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_only_fired_open: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_last |-> rsp_kind == KIND_FIRED)
      else $error("non-final response is not a fired timer");

   a_slot_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_kind == KIND_ERROR || rsp_kind == KIND_DELAY ||
                    rsp_kind == KIND_NONE) |-> rsp_result_slot == 4'd0)
      else $error("slot not zero in slotless response");

   a_fired_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_kind == KIND_FIRED |-> rsp_amount == '0 && rsp_period == '0)
      else $error("fired response carries data");

endmodule

bind deadline_timer_queue_top dtq_checker u_dtq_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_bus.valid),
   .rsp_ready       (rsp_bus.ready),
   .rsp_kind        (rsp_bus.kind),
   .rsp_result_slot (rsp_bus.result_slot),
   .rsp_amount      (rsp_bus.amount),
   .rsp_period      (rsp_bus.period),
   .rsp_last        (rsp_bus.last)
);
`default_nettype wire

[sim/deadline_timer_queue_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Deadline timer queue testbench
// Drives a directed table and then random timer requests through the request
// channel. Each accepted request is run through a local timer table model.
// Every response is compared with the oldest predicted response. Both channels
// idle at random, and the delay limits change between phases while the block
// is idle.
// ----------------------------------------------------------------------------
module deadline_timer_queue_top_tb;
   import dtq_pkg::*;

   localparam int       NumSlots   = 16;
   localparam int       CycleLimit = 1000000;
   localparam int       DrainWait  = 60;
   localparam time_type TimeMax    = {TimeWidth{1'b1}};
   localparam logic [2:0] OpBad6 = 3'd6;
   localparam logic [2:0] OpBad7 = 3'd7;

   typedef struct {
      kind_type   kind;
      logic [3:0] slot;
      time_type   amount;
      time_type   period;
      logic       last;
   } timer_rsp_t;

   typedef struct {
      logic [2:0] op;
      logic [3:0] slot;
      time_type   tv;
      time_type   rl;
      logic       absolute;
      time_type   now;
      logic       typed;
      kind_type   tkind;
      logic [3:0] tslot;
   } stim_row_t;

   logic clock;
   logic reset;
   logic        csr_write_enable;
   logic        csr_index;
   logic [31:0] csr_write_data;

   dtq_req_if req_bus ();
   dtq_rsp_if rsp_bus ();

   deadline_timer_queue_top #(.NUM_SLOTS(NumSlots)) dut (
      .clock            (clock),
      .reset            (reset),
      .req_bus          (req_bus.sink),
      .rsp_bus          (rsp_bus.source),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   // Local copy of the timer table and the delay limits
   logic        slot_used [NumSlots];
   logic        slot_armed [NumSlots];
   time_type    slot_expiry [NumSlots];
   time_type    slot_interval [NumSlots];
   logic [31:0] lim_min;
   logic [31:0] lim_max;

   timer_rsp_t  pending_rsp [$];
   stim_row_t   directed [$];
   int          failures;
   int          cycles;
   int          hold_cnt;
   time_type    base_now;

   always begin
      clock = 1'b1;
      #10;
      clock = 1'b0;
      #10;
   end

   function automatic time_type add_sat(input time_type a, input time_type b);
      logic [TimeWidth:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[TimeWidth] ? TimeMax : s[TimeWidth-1:0];
   endfunction

   function automatic time_type time_left(input int s, input time_type now);
      return slot_expiry[s] > now ? slot_expiry[s] - now : '0;
   endfunction

   task automatic push_rsp(input kind_type k, input logic [3:0] s, input time_type a,
                           input time_type p);
      timer_rsp_t r;
      r.kind = k;
      r.slot = s;
      r.amount = a;
      r.period = p;
      r.last = 1'b0;
      pending_rsp.push_back(r);
   endtask

   // Advance the local timer table by one request and queue its responses
   task automatic predict_timer(input logic [2:0] op, input logic [3:0] s, input time_type tv,
                                input time_type rl, input logic absolute, input time_type now);
      int       i;
      logic     any;
      time_type best;
      time_type d;
      time_type old_rem;
      time_type old_int;
      logic     slot_ok;
      slot_ok = slot_used[s];
      case (op)
         OP_ALLOC: begin
            for (i = 0; i < NumSlots; i++)
               if (!slot_used[i]) break;
            if (i >= NumSlots) begin
               push_rsp(KIND_ERROR, '0, '0, '0);
            end else begin
               slot_used[i] = 1'b1;
               slot_armed[i] = 1'b0;
               slot_expiry[i] = '0;
               slot_interval[i] = '0;
               push_rsp(KIND_OK, i[3:0], '0, '0);
            end
         end
         OP_RELEASE, OP_DISARM, OP_QUERY, OP_ARM: begin
            if (!slot_ok) begin
               push_rsp(KIND_ERROR, '0, '0, '0);
            end else if (op == OP_RELEASE) begin
               slot_used[s] = 1'b0;
               slot_armed[s] = 1'b0;
               push_rsp(KIND_OK, s, '0, '0);
            end else if (op == OP_DISARM) begin
               slot_armed[s] = 1'b0;
               push_rsp(KIND_OK, s, '0, '0);
            end else if (op == OP_QUERY) begin
               if (slot_armed[s]) push_rsp(KIND_QUERY, s, time_left(s, now), slot_interval[s]);
               else push_rsp(KIND_QUERY, s, '0, '0);
            end else begin
               // rearm: report the old timer, then start the new one unless zero
               old_rem = '0;
               old_int = '0;
               if (slot_armed[s]) begin
                  old_rem = time_left(s, now);
                  old_int = slot_interval[s];
                  slot_armed[s] = 1'b0;
               end
               if (tv != '0) begin
                  slot_expiry[s] = absolute ? tv : add_sat(tv, now);
                  slot_interval[s] = rl;
                  slot_armed[s] = 1'b1;
               end
               push_rsp(KIND_OK, s, old_rem, old_int);
            end
         end
         OP_TICK: begin
            any = 1'b0;
            best = '0;
            for (i = 0; i < NumSlots; i++) begin
               if (slot_armed[i] && slot_expiry[i] <= now) begin
                  push_rsp(KIND_FIRED, i[3:0], '0, '0);
                  if (slot_interval[i] != '0) slot_expiry[i] = add_sat(now, slot_interval[i]);
                  else slot_armed[i] = 1'b0;
               end
            end
            for (i = 0; i < NumSlots; i++) begin
               if (slot_armed[i] && (!any || slot_expiry[i] < best)) begin
                  best = slot_expiry[i];
                  any = 1'b1;
               end
            end
            if (!any) begin
               push_rsp(KIND_NONE, '0, '0, '0);
            end else begin
               d = best > now ? best - now : '0;
               // min clamp wins over max clamp
               if (d < {31'd0, lim_min}) d = {31'd0, lim_min};
               else if (d > {31'd0, lim_max}) d = {31'd0, lim_max};
               push_rsp(KIND_DELAY, '0, d, '0);
            end
         end
         default: push_rsp(KIND_ERROR, '0, '0, '0);
      endcase
      pending_rsp[pending_rsp.size()-1].last = 1'b1;
   endtask

   // Drive one request, hold it until accepted, then predict or take the typed value
   task automatic send_request(input stim_row_t r);
      timer_rsp_t t;
      req_bus.valid      <= 1'b1;
      req_bus.operation  <= r.op;
      req_bus.slot       <= r.slot;
      req_bus.time_value <= r.tv;
      req_bus.reload     <= r.rl;
      req_bus.absolute   <= r.absolute;
      req_bus.now        <= r.now;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      predict_timer(r.op, r.slot, r.tv, r.rl, r.absolute, r.now);
      if (r.typed) begin
         // typed rows yield exactly one response: replace the prediction
         t.kind = r.tkind;
         t.slot = r.tslot;
         t.amount = '0;
         t.period = '0;
         t.last = 1'b1;
         pending_rsp[pending_rsp.size()-1] = t;
      end
   endtask

   // Drop valid for a random gap: mostly short, sometimes long
   task automatic req_gap();
      int n;
      n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(0, 2);
      if (n > 0) begin
         req_bus.valid <= 1'b0;
         repeat (n) @(posedge clock);
      end
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DrainWait) @(posedge clock);
   endtask

   task automatic write_limits(input logic [31:0] mn, input logic [31:0] mx);
      wait_drained();
      csr_write_enable <= 1'b1;
      csr_index        <= CSR_MIN_DELAY;
      csr_write_data   <= mn;
      @(posedge clock);
      csr_index        <= CSR_MAX_DELAY;
      csr_write_data   <= mx;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      @(posedge clock);
      lim_min = mn;
      lim_max = mx;
   endtask

   task automatic add_row(input logic [2:0] op, input logic [3:0] s, input time_type tv,
                          input time_type rl, input logic absolute, input time_type now,
                          input logic typed, input kind_type k, input logic [3:0] ts);
      stim_row_t r;
      r.op = op; r.slot = s; r.tv = tv; r.rl = rl; r.absolute = absolute; r.now = now;
      r.typed = typed; r.tkind = k; r.tslot = ts;
      directed.push_back(r);
   endtask

   function automatic time_type rand_wide();
      return time_type'({$urandom, $urandom});
   endfunction

   // Pick an in-use slot most of the time so arm/tick/query reach deep state
   function automatic logic [3:0] pick_slot();
      int cand [$];
      int i;
      for (i = 0; i < NumSlots; i++)
         if (slot_used[i]) cand.push_back(i);
      if (cand.size() == 0 || $urandom_range(0, 9) == 0) return 4'($urandom_range(0, 15));
      return 4'(cand[$urandom_range(0, cand.size()-1)]);
   endfunction

   function automatic stim_row_t rand_row();
      stim_row_t r;
      int w;
      r.typed = 1'b0;
      r.tkind = KIND_OK;
      r.tslot = '0;
      w = $urandom_range(0, 99);
      if (w < 14) r.op = OP_ALLOC;
      else if (w < 22) r.op = OP_RELEASE;
      else if (w < 50) r.op = OP_ARM;
      else if (w < 56) r.op = OP_DISARM;
      else if (w < 82) r.op = OP_TICK;
      else if (w < 97) r.op = OP_QUERY;
      else r.op = 3'($urandom_range(6, 7));
      r.slot = pick_slot();
      // advance the time base; now occasionally jumps anywhere
      base_now = add_sat(base_now, time_type'($urandom_range(0, 3000)));
      r.now = ($urandom_range(0, 15) == 0) ? rand_wide() : base_now;
      r.absolute = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 9))
         0: r.tv = rand_wide();
         1: r.tv = TimeMax;
         2: r.tv = '0;
         default: r.tv = r.absolute ? add_sat(r.now, time_type'($urandom_range(0, 6000)))
                                    : time_type'($urandom_range(1, 6000));
      endcase
      case ($urandom_range(0, 9))
         0: r.rl = rand_wide();
         1: r.rl = TimeMax;
         2, 3, 4: r.rl = time_type'($urandom_range(1, 5000));
         default: r.rl = '0;
      endcase
      return r;
   endfunction

   // Response side: random stalls, and check each accepted response
   always @(posedge clock) begin
      timer_rsp_t e;
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("CHECK FAILED");
         $finish;
      end
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         hold_cnt <= 0;
      end else begin
         // hold ready low through a long stall, otherwise toggle it briefly
         if (hold_cnt != 0) begin
            rsp_bus.ready <= 1'b0;
            hold_cnt <= hold_cnt - 1;
         end else if ($urandom_range(0, 299) < 2) begin
            rsp_bus.ready <= 1'b0;
            hold_cnt <= $urandom_range(10, 40);
         end else if ($urandom_range(0, 3) == 0) rsp_bus.ready <= ~rsp_bus.ready;
         else if (!rsp_bus.ready) rsp_bus.ready <= ($urandom_range(0, 4) != 0);
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (pending_rsp.size() == 0) begin
               $error("response with none expected: kind %0d slot %0d", rsp_bus.kind,
                      rsp_bus.result_slot);
               failures <= failures + 1;
            end else begin
               e = pending_rsp.pop_front();
               if (rsp_bus.kind !== e.kind || rsp_bus.result_slot !== e.slot ||
                   rsp_bus.amount !== e.amount || rsp_bus.period !== e.period ||
                   rsp_bus.last !== e.last)
                  failures <= failures + 1;
               if (rsp_bus.kind !== e.kind)
                  $error("kind: expected %0d, actual %0d", e.kind, rsp_bus.kind);
               if (rsp_bus.result_slot !== e.slot)
                  $error("result_slot: expected %0d, actual %0d", e.slot, rsp_bus.result_slot);
               if (rsp_bus.amount !== e.amount)
                  $error("amount: expected %0d, actual %0d", e.amount, rsp_bus.amount);
               if (rsp_bus.period !== e.period)
                  $error("period: expected %0d, actual %0d", e.period, rsp_bus.period);
               if (rsp_bus.last !== e.last)
                  $error("last: expected %0d, actual %0d", e.last, rsp_bus.last);
            end
         end
      end
   end

   initial begin
      int        i;
      int        ph;
      stim_row_t r;
      failures = 0;
      cycles = 0;
      base_now = 63'd5000;
      lim_min = 32'd1000;
      lim_max = 32'hFFFF_FFFF;
      for (i = 0; i < NumSlots; i++) begin
         slot_used[i] = 1'b0;
         slot_armed[i] = 1'b0;
         slot_expiry[i] = '0;
         slot_interval[i] = '0;
      end
      reset = 1'b1;
      csr_write_enable = 1'b0;
      csr_index = CSR_MIN_DELAY;
      csr_write_data = '0;
      req_bus.valid = 1'b0;
      req_bus.operation = OP_ALLOC;
      req_bus.slot = '0;
      req_bus.time_value = '0;
      req_bus.reload = '0;
      req_bus.absolute = 1'b0;
      req_bus.now = '0;
      rsp_bus.ready = 1'b0;
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed table: empty table, bad slots, bad codes, one slot's life, then a full table
      add_row(OP_TICK,    4'd0,  '0, '0, 1'b0, '0, 1'b1, KIND_NONE, 4'd0);
      add_row(OP_QUERY,   4'd15, '0, '0, 1'b0, '0, 1'b1, KIND_ERROR, 4'd0);
      add_row(OP_RELEASE, 4'd0,  '0, '0, 1'b0, '0, 1'b1, KIND_ERROR, 4'd0);
      add_row(OpBad6,     4'd3,  TimeMax, TimeMax, 1'b1, TimeMax, 1'b1, KIND_ERROR, 4'd0);
      add_row(OpBad7,     4'd15, '0, '0, 1'b0, '0, 1'b1, KIND_ERROR, 4'd0);
      add_row(OP_ALLOC,   4'd9,  '0, '0, 1'b0, '0, 1'b1, KIND_OK, 4'd0);
      add_row(OP_ARM,     4'd0,  63'd500, '0, 1'b0, 63'd100, 1'b0, KIND_OK, 4'd0);
      add_row(OP_QUERY,   4'd0,  '0, '0, 1'b0, 63'd300, 1'b0, KIND_OK, 4'd0);
      add_row(OP_TICK,    4'd0,  '0, '0, 1'b0, 63'd600, 1'b0, KIND_OK, 4'd0);
      add_row(OP_ARM,     4'd0,  TimeMax, TimeMax, 1'b0, TimeMax, 1'b0, KIND_OK, 4'd0);
      add_row(OP_QUERY,   4'd0,  '0, '0, 1'b0, '0, 1'b0, KIND_OK, 4'd0);
      add_row(OP_ARM,     4'd0,  '0, '0, 1'b0, 63'd10, 1'b0, KIND_OK, 4'd0);
      add_row(OP_ARM,     4'd0,  63'd1000, 63'd50, 1'b1, 63'd900, 1'b0, KIND_OK, 4'd0);
      add_row(OP_TICK,    4'd0,  '0, '0, 1'b0, 63'd1000, 1'b0, KIND_OK, 4'd0);
      add_row(OP_QUERY,   4'd0,  '0, '0, 1'b0, 63'd1020, 1'b0, KIND_OK, 4'd0);
      add_row(OP_QUERY,   4'd0,  '0, '0, 1'b0, 63'd9000, 1'b0, KIND_OK, 4'd0);
      add_row(OP_DISARM,  4'd0,  '0, '0, 1'b0, '0, 1'b0, KIND_OK, 4'd0);
      add_row(OP_QUERY,   4'd0,  '0, '0, 1'b0, '0, 1'b0, KIND_OK, 4'd0);
      add_row(OP_TICK,    4'd0,  '0, '0, 1'b0, TimeMax, 1'b0, KIND_OK, 4'd0);
      for (i = 0; i < NumSlots; i++)
         add_row(OP_ALLOC, 4'd0, '0, '0, 1'b0, '0, 1'b0, KIND_OK, 4'd0);
      add_row(OP_RELEASE, 4'd5, '0, '0, 1'b0, '0, 1'b0, KIND_OK, 4'd0);
      foreach (directed[i]) begin
         send_request(directed[i]);
         req_gap();
      end

      // Random phases, each with its own delay limits
      for (ph = 0; ph < 5; ph++) begin
         case (ph)
            0: write_limits(32'd1000, 32'hFFFF_FFFF);
            1: write_limits(32'd0, 32'd0);
            2: write_limits(32'hFFFF_FFFF, 32'd0);
            3: write_limits(32'd0, 32'hFFFF_FFFF);
            default: write_limits($urandom_range(0, 3000), $urandom_range(0, 6000));
         endcase
         for (i = 0; i < 25; i++) begin
            r = rand_row();
            send_request(r);
            // hold off until the block has answered everything
            if (i == 16) wait_drained();
            else if ($urandom_range(0, 3) != 0) req_gap();
         end
      end

      wait_drained();
      if (failures == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
